// ===== design/zx_screen_scan_generator_unit_macros.svh =====
// assertion helpers for the scan generator checker
`ifndef ZX_SCREEN_SCAN_GENERATOR_UNIT_MACROS_SVH
`define ZX_SCREEN_SCAN_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ZXSSG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define ZXSSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/zxssg_pkg.sv =====
package zxssg_pkg;

   localparam int unsigned ScreenBytes   = 6912;
   localparam int unsigned AddrWidth     = 13;
   localparam int unsigned CsrAddrWidth  = 3;

   localparam logic [7:0]  TopRows       = 8'd24;
   localparam logic [7:0]  ScreenEndRow  = 8'd216;
   localparam logic [7:0]  LastRow       = 8'd239;
   localparam logic [3:0]  LastChunk     = 4'd9;
   localparam logic [3:0]  LastWord      = 4'd15;
   localparam logic [15:0] PeriodReset   = 16'd960;
   localparam logic        CsrIdxPeriod  = 1'b0;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_BORDER = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      JOB_BUSY   = 2'd0,
      JOB_BORDER = 2'd1,
      JOB_SCREEN = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic                 link_busy;
      logic [AddrWidth-1:0] address;
      logic [7:0]           data;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] pixel_pair;
      logic        pixels_valid;
      logic        frame_irq;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      job_kind_type         kind;
      logic                 irq;
      logic [15:0]          border_color;
      logic                 blink;
      logic [AddrWidth-3:0] pix_base;
      logic [AddrWidth-3:0] att_base;
   } job_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] pix_addr;
      logic [AddrWidth-1:0] att_addr;
   } mem_read_type;

   typedef struct packed {
      logic [7:0] pix;
      logic [7:0] att;
   } mem_data_type;

   function automatic logic [15:0] palette_color(input logic [3:0] idx);
      logic [15:0] color;
      case (idx)
         4'd0:    color = 16'h0000;
         4'd1:    color = 16'h7800;
         4'd2:    color = 16'h03E0;
         4'd3:    color = 16'h7BE0;
         4'd4:    color = 16'h000F;
         4'd5:    color = 16'h780F;
         4'd6:    color = 16'h03EF;
         4'd7:    color = 16'h7BEF;
         4'd8:    color = 16'h0000;
         4'd9:    color = 16'hF800;
         4'd10:   color = 16'h07E0;
         4'd11:   color = 16'hFFE0;
         4'd12:   color = 16'h001F;
         4'd13:   color = 16'hF81F;
         4'd14:   color = 16'h07FF;
         4'd15:   color = 16'hFFFF;
         default: color = 16'h0000;
      endcase
      return color;
   endfunction

endpackage

// ===== design/zx_screen_scan_generator_unit.sv =====
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_payload_type (mode, link_busy, address, data)
// rsp       out        rsp_valid/stall    rsp_payload_type (pixel_pair, pixels_valid, ...)
// csr       in         APB write/read     frame_irq_period at byte address 0
//
// A write or border request yields no beat; a tick streams 16 beats, one per cycle while rsp is not stalled.
// A tick holds the input channel until its last beat enters the output register,
// so a new tick is taken only as the previous tick finishes its beats.
// A busy tick yields a single beat.
// After reset all 6912 bytes of the screen memory are swept to zero; req is stalled meanwhile.
// A stall on rsp freezes the word sequencer and, through it, the req channel.
module zx_screen_scan_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  zxssg_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output zxssg_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [zxssg_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import zxssg_pkg::*;

   logic [3:0]   chunk_ff;
   logic [3:0]   chunk_in;
   logic [7:0]   row_ff;
   logic [7:0]   row_in;
   logic [7:0]   blink_ff;
   logic [7:0]   blink_in;
   logic [15:0]  tick_ff;
   logic [15:0]  tick_in;
   logic [2:0]   border_ff;
   logic [2:0]   border_in;
   logic [15:0]  period_ff;
   logic [15:0]  period_in;

   logic         accept;
   logic         tick;
   logic         csr_write;
   logic [15:0]  tick_inc;
   logic         fire;
   logic         border_row;
   logic         is_border;
   logic [7:0]   scr_y;
   logic [2:0]   chunk_m1;
   job_type      job;
   logic         job_ready;
   logic         clearing;
   mem_read_type rd;
   mem_data_type rd_data;

   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (req_payload.mode == MODE_TICK);
   assign req_stall = clearing || !job_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign tick_inc   = tick_ff + 16'd1;
   assign fire       = (tick_inc >= period_ff);
   assign border_row = (row_ff < TopRows) || (row_ff >= ScreenEndRow);
   assign is_border  = border_row || (chunk_ff == 4'd0) || (chunk_ff >= LastChunk);
   assign scr_y      = row_ff - TopRows;
   assign chunk_m1   = 3'(chunk_ff - 4'd1);

   always_comb begin
      job.kind         = req_payload.link_busy ? JOB_BUSY :
                         (is_border ? JOB_BORDER : JOB_SCREEN);
      job.irq          = fire;
      job.border_color = palette_color({1'b0, border_ff});
      job.blink        = blink_ff[4];
      job.pix_base     = {scr_y[7:6], scr_y[2:0], scr_y[5:3], chunk_m1};
      job.att_base     = {3'b110, scr_y[7:3], chunk_m1};
   end

   always_comb begin
      chunk_in  = chunk_ff;
      row_in    = row_ff;
      blink_in  = blink_ff;
      tick_in   = tick_ff;
      border_in = border_ff;
      period_in = period_ff;
      if (tick) begin
         tick_in = fire ? 16'd0 : tick_inc;
         if (!req_payload.link_busy) begin
            if (!is_border) begin
               chunk_in = chunk_ff + 4'd1;
            end else if (chunk_ff >= LastChunk) begin
               chunk_in = 4'd0;
               if (border_row && (row_ff >= LastRow)) begin
                  row_in   = 8'd0;
                  blink_in = blink_ff + 8'd1;
               end else begin
                  row_in = row_ff + 8'd1;
               end
            end else begin
               chunk_in = chunk_ff + 4'd1;
            end
         end
      end
      if (accept && (req_payload.mode == MODE_BORDER)) begin
         border_in = req_payload.data[2:0];
      end
      if (csr_write && (csr_paddr[2] == CsrIdxPeriod)) begin
         period_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff  <= 4'd0;
         row_ff    <= 8'd0;
         blink_ff  <= 8'd0;
         tick_ff   <= 16'd0;
         border_ff <= 3'd0;
         period_ff <= PeriodReset;
      end else begin
         chunk_ff  <= chunk_in;
         row_ff    <= row_in;
         blink_ff  <= blink_in;
         tick_ff   <= tick_in;
         border_ff <= border_in;
         period_ff <= period_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CsrIdxPeriod) ? {16'd0, period_ff} : 32'd0;

   zxssg_screen_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_payload.mode == MODE_WRITE)),
      .wr_addr  (req_payload.address),
      .wr_data  (req_payload.data),
      .rd       (rd),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   zxssg_word_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (tick),
      .job         (job),
      .job_ready   (job_ready),
      .rd          (rd),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/zxssg_screen_mem.sv =====
module zxssg_screen_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [zxssg_pkg::AddrWidth-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   input  zxssg_pkg::mem_read_type        rd,
   output zxssg_pkg::mem_data_type        rd_data,
   output logic                           clearing
);
   import zxssg_pkg::*;

   logic [7:0]           screen_ff [ScreenBytes];
   logic [7:0]           pix_ff;
   logic [7:0]           att_ff;
   logic                 clearing_ff;
   logic                 clearing_in;
   logic [AddrWidth-1:0] clr_addr_ff;
   logic [AddrWidth-1:0] clr_addr_in;
   logic                 clr_done;

   assign clr_done = (clr_addr_ff == AddrWidth'(ScreenBytes - 1));

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AddrWidth'(1);
         if (clr_done) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         screen_ff[clr_addr_ff] <= 8'd0;
      end else if (wr_en && (wr_addr < AddrWidth'(ScreenBytes))) begin
         screen_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         pix_ff <= screen_ff[rd.pix_addr];
         att_ff <= screen_ff[rd.att_addr];
      end
   end

   assign rd_data.pix = pix_ff;
   assign rd_data.att = att_ff;
   assign clearing    = clearing_ff;

endmodule

// ===== design/zxssg_word_engine.sv =====
module zxssg_word_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  zxssg_pkg::job_type        job,
   output logic                      job_ready,
   output zxssg_pkg::mem_read_type   rd,
   input  zxssg_pkg::mem_data_type   rd_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output zxssg_pkg::rsp_payload_type rsp_payload
);
   import zxssg_pkg::*;

   logic            active_ff;
   logic            active_in;
   logic [3:0]      word_ff;
   logic [3:0]      word_in;
   job_type         job_ff;
   job_type         job_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   logic            adv;
   logic            last_word;
   logic            done;
   logic [1:0]      pair_idx;
   logic [2:0]      bit0_sel;
   logic [2:0]      bit1_sel;
   logic [15:0]     ink;
   logic [15:0]     paper;
   logic [15:0]     ink_sw;
   logic [15:0]     paper_sw;
   logic [15:0]     first_px;
   logic [15:0]     second_px;
   rsp_payload_type beat;

   assign adv       = active_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_word = (job_ff.kind == JOB_BUSY) || (word_ff == LastWord);
   assign done      = adv && last_word;
   assign job_ready = !active_ff || done;

   // screen pixel decode for the current word
   assign pair_idx = word_ff[1:0];
   assign bit0_sel = 3'd7 - {pair_idx, 1'b0};
   assign bit1_sel = 3'd6 - {pair_idx, 1'b0};
   assign ink      = palette_color({rd_data.att[6], rd_data.att[2:0]});
   assign paper    = palette_color({rd_data.att[6], rd_data.att[5:3]});

   always_comb begin
      ink_sw   = ink;
      paper_sw = paper;
      if (rd_data.att[7] && job_ff.blink) begin
         ink_sw   = paper;
         paper_sw = ink;
      end
   end

   assign first_px  = rd_data.pix[bit0_sel] ? ink_sw : paper_sw;
   assign second_px = rd_data.pix[bit1_sel] ? ink_sw : paper_sw;

   always_comb begin
      beat.pixels_valid = 1'b1;
      beat.frame_irq    = job_ff.irq && (word_ff == 4'd0);
      beat.last         = last_word;
      case (job_ff.kind)
         JOB_BUSY: begin
            beat.pixel_pair   = 32'd0;
            beat.pixels_valid = 1'b0;
         end
         JOB_BORDER: begin
            beat.pixel_pair = {job_ff.border_color, job_ff.border_color};
         end
         JOB_SCREEN: begin
            beat.pixel_pair = {second_px, first_px};
         end
         default: begin
            beat.pixel_pair = 32'd0;
         end
      endcase
   end

   // fetch the byte pair for each group of four words
   always_comb begin
      rd.en       = 1'b0;
      rd.pix_addr = {job.pix_base, 2'd0};
      rd.att_addr = {job.att_base, 2'd0};
      if (job_valid && (job.kind == JOB_SCREEN)) begin
         rd.en = 1'b1;
      end else if (adv && (job_ff.kind == JOB_SCREEN) && (word_ff[1:0] == 2'd3) &&
                   (word_ff[3:2] != 2'd3)) begin
         rd.en       = 1'b1;
         rd.pix_addr = {job_ff.pix_base, word_ff[3:2] + 2'd1};
         rd.att_addr = {job_ff.att_base, word_ff[3:2] + 2'd1};
      end
   end

   always_comb begin
      active_in    = active_ff;
      word_in      = word_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (job_valid) begin
         active_in = 1'b1;
         word_in   = 4'd0;
         job_in    = job;
      end else if (done) begin
         active_in = 1'b0;
      end else if (adv) begin
         word_in = word_ff + 4'd1;
      end
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_in       = beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/zxssg_checker.sv =====
`include "zx_screen_scan_generator_unit_macros.svh"

module zxssg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input zxssg_pkg::rsp_payload_type rsp_payload,
   input logic                       csr_psel,
   input logic                       csr_pready
);

   `ZXSSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")

   `ZXSSG_ASSERT_NOW(a_clear_stall, clock, reset, $past(reset), req_stall, "req accepted right after reset")

   `ZXSSG_ASSERT_NOW(a_busy_beat, clock, reset, rsp_valid && !rsp_payload.pixels_valid, rsp_payload.last && (rsp_payload.pixel_pair == 32'd0), "busy beat not a lone empty beat")

   `ZXSSG_ASSERT_NEXT(a_irq_first, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last, !(rsp_valid && rsp_payload.frame_irq), "frame irq past first beat")

   `ZXSSG_ASSERT_NOW(a_pready, clock, reset, csr_psel, csr_pready, "csr wait state")

endmodule

bind zx_screen_scan_generator_unit zxssg_checker u_checker (.*);

// ===== tb/sv/zx_screen_scan_generator_unit_test.sv =====
module zx_screen_scan_generator_unit_test;
   import zxssg_pkg::*;

   localparam logic [1:0] ModeUnused = 2'd3;
   localparam logic [CsrAddrWidth-1:0] CsrAddrPeriod = '0;
   localparam logic [CsrAddrWidth-1:0] CsrAddrUnused = CsrAddrWidth'(4);

   localparam int MemBytes = 6912;
   localparam int AttrBase = 6144;
   localparam logic [7:0] TopBorderRows = 8'd24;
   localparam logic [7:0] BottomBorderRow = 8'd216;
   localparam logic [7:0] FinalRow = 8'd239;
   localparam logic [3:0] RightChunk = 4'd9;
   localparam int WordsPerChunk = 16;

   localparam logic [15:0] RedDim = 16'h7800;
   localparam logic [15:0] RedFull = 16'hF800;
   localparam logic [15:0] GreenDim = 16'h03E0;
   localparam logic [15:0] GreenFull = 16'h07E0;
   localparam logic [15:0] BlueDim = 16'h000F;
   localparam logic [15:0] BlueFull = 16'h001F;

   localparam int SettleCycles = 24;
   localparam int TailCycles = 32;
   localparam int MaxReports = 100;
   localparam int PhaseItems = 134;
   localparam int HoldCycles = 300;

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   mode;
      logic         busy;
      logic [12:0]  addr;
      logic [7:0]   data;
      logic [31:0]  csr_value;
      logic         typed;
      logic [31:0]  word;
      logic         irq;
   } step_row_type;

   localparam step_row_type DirectedRows [23] = '{
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b1, 13'd0,    8'h00, 32'd0, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_BORDER, 1'b0, 13'd0,    8'hFF, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h7BEF_7BEF, 1'b0},
      '{ROW_ITEM, MODE_BORDER, 1'b1, 13'h1FFF, 8'hFA, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, ModeUnused,  1'b1, 13'h1FFF, 8'hFF, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'h1FFF, 8'hFF, 32'd0, 1'b1, 32'h03E0_03E0, 1'b0},
      '{ROW_ITEM, MODE_WRITE,  1'b0, 13'd6911, 8'hFF, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_WRITE,  1'b1, 13'd0,    8'h81, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_WRITE,  1'b0, 13'h1FFF, 8'hFF, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_WRITE,  1'b0, 13'd6912, 8'h55, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  MODE_TICK,   1'b0, 13'(CsrAddrPeriod), 8'h00, 32'd1, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b1, 13'd0,    8'h00, 32'd0, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h03E0_03E0, 1'b1},
      '{ROW_CSR,  MODE_TICK,   1'b0, 13'(CsrAddrPeriod), 8'h00, 32'd0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b1, 13'd0,    8'h00, 32'd0, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_CSR,  MODE_TICK,   1'b0, 13'(CsrAddrUnused), 8'h00, 32'd5, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h03E0_03E0, 1'b1},
      '{ROW_CSR,  MODE_TICK,   1'b0, 13'(CsrAddrPeriod), 8'h00, 32'd65535, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h03E0_03E0, 1'b0},
      '{ROW_ITEM, MODE_BORDER, 1'b0, 13'd0,    8'h00, 32'd0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_ITEM, MODE_TICK,   1'b0, 13'd0,    8'h00, 32'd0, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_CSR,  MODE_TICK,   1'b0, 13'(CsrAddrPeriod), 8'h00, 32'hFFFF_0003, 1'b0, 32'h0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // scan state mirrored from the block
   bit [7:0]  mem_image [MemBytes];
   bit [3:0]  chunk_col = '0;
   bit [7:0]  scan_row = '0;
   bit [7:0]  frames_done = '0;
   bit [15:0] tick_cnt = '0;
   bit [2:0]  border_sel = '0;
   bit [15:0] irq_period = 16'd960;

   rsp_payload_type chunk_beats [$];
   rsp_payload_type beats_due [$];

   int sender_idle_pct = 35;
   int receiver_idle_pct = 59;
   int hold_left = 0;
   int fail_count = 0;
   int beats_checked = 0;
   int irq_count = 0;
   int ticks_sent = 0;
   int busy_sent = 0;
   int writes_sent = 0;

   zx_screen_scan_generator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] rgb565(input bit bright, input bit [2:0] color);
      logic [15:0] rgb;
      rgb = '0;
      if (color[0]) rgb = rgb | (bright ? RedFull : RedDim);
      if (color[1]) rgb = rgb | (bright ? GreenFull : GreenDim);
      if (color[2]) rgb = rgb | (bright ? BlueFull : BlueDim);
      return rgb;
   endfunction

   function automatic void push_beat(input bit [31:0] word, input bit pixels,
                                     input bit irq, input bit last);
      rsp_payload_type beat;
      beat.pixel_pair = word;
      beat.pixels_valid = pixels;
      beat.frame_irq = irq;
      beat.last = last;
      chunk_beats.push_back(beat);
   endfunction

   function automatic void compute_chunk(input req_payload_type item);
      bit irq;
      bit border_row;
      bit [15:0] ink;
      bit [15:0] paper;
      bit [15:0] swap;
      bit [15:0] fill;
      bit [7:0] pix;
      bit [7:0] att;
      int y;
      int pix_base;
      int att_base;
      int col;
      chunk_beats.delete();
      if (item.mode == MODE_WRITE) begin
         if (item.address < MemBytes) mem_image[item.address] = item.data;
         return;
      end
      if (item.mode == MODE_BORDER) begin
         border_sel = item.data[2:0];
         return;
      end
      if (item.mode != MODE_TICK) return;
      tick_cnt = tick_cnt + 16'd1;
      irq = 1'b0;
      if (tick_cnt >= irq_period) begin
         irq = 1'b1;
         tick_cnt = '0;
      end
      if (item.link_busy) begin
         push_beat(32'h0, 1'b0, irq, 1'b1);
         return;
      end
      border_row = scan_row < TopBorderRows || scan_row >= BottomBorderRow;
      if (border_row || chunk_col == 4'd0 || chunk_col >= RightChunk) begin
         fill = rgb565(1'b0, border_sel);
         for (int i = 0; i < WordsPerChunk; i++)
            push_beat({fill, fill}, 1'b1, i == 0 ? irq : 1'b0, i == WordsPerChunk - 1);
         if (chunk_col >= RightChunk) begin
            chunk_col = '0;
            if (border_row && scan_row >= FinalRow) begin
               scan_row = '0;
               frames_done = frames_done + 8'd1;
            end else begin
               scan_row = scan_row + 8'd1;
            end
         end else begin
            chunk_col = chunk_col + 4'd1;
         end
         return;
      end
      y = int'(scan_row) - int'(TopBorderRows);
      pix_base = ((y & 'h38) << 2) + ((y & 7) << 8) + ((y & 'hC0) << 5);
      att_base = AttrBase + ((y & 'hF8) << 2);
      for (int k = 0; k < 4; k++) begin
         col = ((int'(chunk_col) - 1) * 4 + k) & 31;
         pix = mem_image[pix_base + col];
         att = mem_image[att_base + col];
         ink = rgb565(att[6], att[2:0]);
         paper = rgb565(att[6], att[5:3]);
         if (att[7] && frames_done[4]) begin
            swap = ink;
            ink = paper;
            paper = swap;
         end
         for (int p = 0; p < 4; p++)
            push_beat({pix[6 - 2 * p] ? ink : paper, pix[7 - 2 * p] ? ink : paper}, 1'b1,
                      (k == 0 && p == 0) ? irq : 1'b0, k == 3 && p == 3);
      end
      chunk_col = chunk_col + 4'd1;
   endfunction

   task automatic send(input req_payload_type item, input bit typed,
                       input bit [31:0] word, input bit irq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      compute_chunk(item);
      if (typed && item.mode == MODE_TICK) begin
         chunk_beats.delete();
         if (item.link_busy) begin
            push_beat(32'h0, 1'b0, irq, 1'b1);
         end else begin
            for (int i = 0; i < WordsPerChunk; i++)
               push_beat(word, 1'b1, i == 0 ? irq : 1'b0, i == WordsPerChunk - 1);
         end
      end
      foreach (chunk_beats[i]) beats_due.push_back(chunk_beats[i]);
      if (item.mode == MODE_TICK) begin
         ticks_sent++;
         if (item.link_busy) busy_sent++;
      end else if (item.mode != ModeUnused) begin
         writes_sent++;
      end
      @(negedge clock);
   endtask

   // hold the input side until every beat is out and the write path is quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (beats_due.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CsrAddrWidth-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_period(input logic [CsrAddrWidth-1:0] addr, input logic [31:0] value);
      logic [31:0] rdata;
      settle();
      csr_access(1'b1, addr, value, rdata);
      if (addr == CsrAddrPeriod) irq_period = value[15:0];
      csr_access(1'b0, CsrAddrPeriod, 32'h0, rdata);
      if (rdata !== {16'h0, irq_period}) begin
         fail_count++;
         if (fail_count <= MaxReports)
            $display("%0t: period read back expected %h actual %h",
                     $time, {16'h0, irq_period}, rdata);
      end
   endtask

   function automatic req_payload_type random_item();
      req_payload_type item;
      int pick;
      item.link_busy = $urandom_range(7) == 0;
      item.address = 13'($urandom_range(8191));
      item.data = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 75) begin
         item.mode = MODE_TICK;
      end else if (pick < 90) begin
         item.mode = MODE_WRITE;
         // aim most writes at the top screen band that the scan reaches
         case ($urandom_range(3))
            0: item.address = 13'($urandom_range(8191));
            1: item.address = 13'(AttrBase + $urandom_range(31));
            default: item.address = 13'(($urandom_range(3) << 8) + $urandom_range(31));
         endcase
      end else if (pick < 96) begin
         item.mode = MODE_BORDER;
      end else begin
         item.mode = ModeUnused;
      end
      return item;
   endfunction

   task automatic run_random(input int count);
      req_payload_type item;
      for (int n = 0; n < count; n++) begin
         item = random_item();
         send(item, 1'b0, 32'h0, 1'b0);
      end
   endtask

   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_beats
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (rsp_payload.frame_irq === 1'b1) irq_count++;
         if (beats_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MaxReports)
               $display("%0t: beat with nothing expected, actual %h/%b/%b/%b", $time,
                        rsp_payload.pixel_pair, rsp_payload.pixels_valid,
                        rsp_payload.frame_irq, rsp_payload.last);
         end else begin
            want = beats_due.pop_front();
            beats_checked++;
            if (rsp_payload.pixel_pair !== want.pixel_pair ||
                rsp_payload.pixels_valid !== want.pixels_valid ||
                rsp_payload.frame_irq !== want.frame_irq ||
                rsp_payload.last !== want.last) begin
               fail_count++;
               if (fail_count <= MaxReports)
                  $display("%0t: beat mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b",
                           $time, want.pixel_pair, want.pixels_valid, want.frame_irq,
                           want.last, rsp_payload.pixel_pair, rsp_payload.pixels_valid,
                           rsp_payload.frame_irq, rsp_payload.last);
            end
         end
      end
   end

   initial begin : limit
      #100_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      step_row_type row;
      req_payload_type item;
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DirectedRows[i]) begin
         row = DirectedRows[i];
         if (row.kind == ROW_CSR) begin
            program_period(row.addr[CsrAddrWidth-1:0], row.csr_value);
         end else begin
            item.mode = row.mode;
            item.link_busy = row.busy;
            item.address = row.addr;
            item.data = row.data;
            send(item, row.typed, row.word, row.irq);
         end
      end

      program_period(CsrAddrPeriod, $urandom_range(2, 12));
      hold_left = HoldCycles;
      run_random(PhaseItems);

      sender_idle_pct = 59;
      receiver_idle_pct = 35;
      program_period(CsrAddrPeriod, $urandom_range(1, 65535));
      run_random(PhaseItems);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      program_period(CsrAddrPeriod, $urandom_range(1, 40));
      run_random(PhaseItems);

      req_valid <= 1'b0;
      waited = 0;
      while (beats_due.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      if (beats_due.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
      end
      repeat (TailCycles) @(negedge clock);

      $display("Sent %0d ticks (%0d with the link busy) and %0d memory or border writes.",
               ticks_sent, busy_sent, writes_sent);
      $display("Checked %0d beats and %0d frame interrupts; the scan reached row %0d.",
               beats_checked, irq_count, scan_row);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
